>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tdcm_pkg.sv
// ----------------------------------------------------------------------------
// tdcm_pkg
// Shared constants and block-scaling helpers for the bar rotation matrix core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdcm_pkg;

  // scaled vectors keep their largest magnitude in [2^29, 2^30)
  localparam int SCALE_POS  = 29;
  localparam int MAG_W      = 30;
  localparam int SCL_W      = 31;
  localparam int SQRT_STEPS = 32;
  localparam int FRONT_LAT  = 10;

  function automatic logic [63:0] mag64(logic signed [63:0] v);
    logic signed [63:0] n;
    n = -v;
    return v[63] ? n : v;
  endfunction

  function automatic logic [63:0] max3(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [63:0] m;
    m = (a > b) ? a : b;
    return (c > m) ? c : m;
  endfunction

  function automatic logic [5:0] lead_pos(logic [63:0] m);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < 64; i++) begin
      if (m[i]) pos = 6'(i);
    end
    return pos;
  endfunction

  // shift a magnitude so that a leading one at pos lands on SCALE_POS
  function automatic logic [MAG_W-1:0] scale_mag(logic [63:0] m, logic [5:0] pos);
    logic [63:0] t;
    if (pos >= 6'(SCALE_POS)) t = m >> (pos - 6'(SCALE_POS));
    else t = m << (6'(SCALE_POS) - pos);
    return t[MAG_W-1:0];
  endfunction

  function automatic logic signed [SCL_W-1:0] apply_sign(logic [MAG_W-1:0] m, logic neg);
    logic signed [SCL_W-1:0] s;
    s = signed'({1'b0, m});
    return neg ? -s : s;
  endfunction

endpackage

>>> rtl/truss_direction_cosine_matrix_core.sv
// ----------------------------------------------------------------------------
// truss_direction_cosine_matrix_core
// Takes the two end nodes of a bar and returns its 3x3 rotation matrix.
// One request enters per cycle while req_stall is low and results come out
// in order after ten stages of difference, block scaling and cross product,
// then per row three stages of squaring, a 32-stage square root and a
// restoring divider that produces one quotient bit per stage, plus rounding
// and saturation. Coincident nodes give an all-zero matrix with degenerate
// set. An output register with a skid slot keeps requests flowing while a
// result waits; req_stall rises only once the skid slot is in use. No state
// survives between requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module truss_direction_cosine_matrix_core import tdcm_pkg::*; #(
  parameter int COORD_BITS = 32,
  parameter int OUT_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_stall,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] start_z,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic signed [COORD_BITS-1:0] end_z,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic signed [OUT_BITS-1:0]   axis_cos_x,
  output logic signed [OUT_BITS-1:0]   axis_cos_y,
  output logic signed [OUT_BITS-1:0]   axis_cos_z,
  output logic signed [OUT_BITS-1:0]   perp_cos_x,
  output logic signed [OUT_BITS-1:0]   perp_cos_y,
  output logic signed [OUT_BITS-1:0]   perp_cos_z,
  output logic signed [OUT_BITS-1:0]   third_cos_x,
  output logic signed [OUT_BITS-1:0]   third_cos_y,
  output logic signed [OUT_BITS-1:0]   third_cos_z,
  output logic                         degenerate
);

  localparam int DW       = COORD_BITS + 1;
  localparam int NORM_LAT = OUT_BITS + 36;
  localparam int LAT      = FRONT_LAT + NORM_LAT;
  localparam int PW       = SCL_W + 1;
  localparam int XW       = SCL_W + PW;

  logic en;
  logic sk_vld;
  logic vp [1:LAT];
  logic dp [1:LAT];

  logic signed [DW-1:0]    d1 [3];
  logic [63:0]             m2 [3];
  logic                    n2 [3];
  logic [63:0]             mx2;
  logic [63:0]             m3 [3];
  logic                    n3 [3];
  logic [5:0]              pos3;
  logic signed [SCL_W-1:0] d4 [3], d5 [3], d6 [3], d7 [3], d8 [3], d9 [3], d10 [3];
  logic signed [PW-1:0]    p5 [3];
  logic signed [XW-1:0]    prod6 [6];
  logic [63:0]             pm6 [3], pm7 [3];
  logic                    pn6 [3], pn7 [3];
  logic [63:0]             pmx6;
  logic [5:0]              ppos7;
  logic signed [63:0]      c7 [3];
  logic signed [SCL_W-1:0] p8 [3], p9 [3], p10 [3];
  logic [63:0]             cm8 [3], cm9 [3];
  logic                    cn8 [3], cn9 [3];
  logic [63:0]             cmx8;
  logic [5:0]              cpos9;
  logic signed [SCL_W-1:0] c10 [3];

  logic signed [63:0]      dext [3];
  logic [63:0]             dmag [3];
  logic signed [PW-1:0]    de [3];
  logic signed [PW-1:0]    dt;
  logic signed [PW-1:0]    pv [3];
  logic [63:0]             pmag [3];
  logic [63:0]             cmag [3];

  logic signed [OUT_BITS-1:0] ua [3], up [3], uc [3];
  logic signed [OUT_BITS-1:0] pipe_cos [9];
  logic signed [OUT_BITS-1:0] o_cos [9];
  logic signed [OUT_BITS-1:0] sk_cos [9];
  logic                       o_deg, sk_deg;

  assign en        = !sk_vld;
  assign req_stall = sk_vld;

  // front end helpers
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dext[i] = {{(64-DW){d1[i][DW-1]}}, d1[i]};
      dmag[i] = mag64(dext[i]);
      de[i]   = PW'(d4[i]);
      pmag[i] = mag64({{(64-PW){p5[i][PW-1]}}, p5[i]});
      cmag[i] = mag64(c7[i]);
    end
    dt = de[1] + de[2];
    // perpendicular picked on the first nonzero axis component
    if (de[0] != '0) begin
      pv[0] = de[0][PW-1] ? dt : -dt;
      pv[1] = de[0][PW-1] ? -de[0] : de[0];
      pv[2] = pv[1];
    end else if (de[1] != '0) begin
      pv[0] = de[1][PW-1] ? -de[1] : de[1];
      pv[1] = de[1][PW-1] ? de[2] : -de[2];
      pv[2] = pv[0];
    end else begin
      pv[0] = de[2][PW-1] ? -de[2] : de[2];
      pv[1] = pv[0];
      pv[2] = de[2][PW-1] ? de[1] : -de[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= DW'(end_x) - DW'(start_x);
      d1[1] <= DW'(end_y) - DW'(start_y);
      d1[2] <= DW'(end_z) - DW'(start_z);
      mx2   <= max3(dmag[0], dmag[1], dmag[2]);
      pos3  <= lead_pos(mx2);
      pmx6  <= max3(pmag[0], pmag[1], pmag[2]);
      ppos7 <= lead_pos(pmx6);
      cmx8  <= max3(cmag[0], cmag[1], cmag[2]);
      cpos9 <= lead_pos(cmx8);
      prod6[0] <= XW'(d5[1]) * XW'(p5[2]);
      prod6[1] <= XW'(d5[2]) * XW'(p5[1]);
      prod6[2] <= XW'(d5[2]) * XW'(p5[0]);
      prod6[3] <= XW'(d5[0]) * XW'(p5[2]);
      prod6[4] <= XW'(d5[0]) * XW'(p5[1]);
      prod6[5] <= XW'(d5[1]) * XW'(p5[0]);
      for (int i = 0; i < 3; i++) begin
        m2[i]  <= dmag[i];
        n2[i]  <= d1[i][DW-1];
        m3[i]  <= m2[i];
        n3[i]  <= n2[i];
        d4[i]  <= apply_sign(scale_mag(m3[i], pos3), n3[i]);
        d5[i]  <= d4[i];
        p5[i]  <= pv[i];
        d6[i]  <= d5[i];
        pm6[i] <= pmag[i];
        pn6[i] <= p5[i][PW-1];
        d7[i]  <= d6[i];
        c7[i]  <= 64'(prod6[2*i]) - 64'(prod6[2*i+1]);
        pm7[i] <= pm6[i];
        pn7[i] <= pn6[i];
        d8[i]  <= d7[i];
        p8[i]  <= apply_sign(scale_mag(pm7[i], ppos7), pn7[i]);
        cm8[i] <= cmag[i];
        cn8[i] <= c7[i][63];
        d9[i]  <= d8[i];
        p9[i]  <= p8[i];
        cm9[i] <= cm8[i];
        cn9[i] <= cn8[i];
        d10[i] <= d9[i];
        p10[i] <= p9[i];
        c10[i] <= apply_sign(scale_mag(cm9[i], cpos9), cn9[i]);
      end
    end
  end

  // valid and degenerate flags travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 1; s <= LAT; s++) vp[s] <= 1'b0;
    end else if (en) begin
      vp[1] <= req_valid;
      for (int s = 2; s <= LAT; s++) vp[s] <= vp[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp[1] <= (end_x == start_x) && (end_y == start_y) && (end_z == start_z);
      for (int s = 2; s <= LAT; s++) dp[s] <= dp[s-1];
    end
  end

  tdcm_norm #(.OUT_BITS(OUT_BITS)) u_norm_axis (.clk(clk), .en(en), .v(d10), .u(ua));
  tdcm_norm #(.OUT_BITS(OUT_BITS)) u_norm_perp (.clk(clk), .en(en), .v(p10), .u(up));
  tdcm_norm #(.OUT_BITS(OUT_BITS)) u_norm_third (.clk(clk), .en(en), .v(c10), .u(uc));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pipe_cos[i]   = ua[i];
      pipe_cos[3+i] = up[i];
      pipe_cos[6+i] = uc[i];
    end
  end

  // output register with one skid slot
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      sk_vld    <= 1'b0;
    end else if (en && vp[LAT]) begin
      if (!res_valid || !res_stall) res_valid <= 1'b1;
      else sk_vld <= 1'b1;
    end else if (res_valid && !res_stall) begin
      if (sk_vld) sk_vld <= 1'b0;
      else res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vp[LAT]) begin
      if (!res_valid || !res_stall) begin
        o_cos <= pipe_cos;
        o_deg <= dp[LAT];
      end else begin
        sk_cos <= pipe_cos;
        sk_deg <= dp[LAT];
      end
    end else if (sk_vld && res_valid && !res_stall) begin
      o_cos <= sk_cos;
      o_deg <= sk_deg;
    end
  end

  assign axis_cos_x  = o_cos[0];
  assign axis_cos_y  = o_cos[1];
  assign axis_cos_z  = o_cos[2];
  assign perp_cos_x  = o_cos[3];
  assign perp_cos_y  = o_cos[4];
  assign perp_cos_z  = o_cos[5];
  assign third_cos_x = o_cos[6];
  assign third_cos_y = o_cos[7];
  assign third_cos_z = o_cos[8];
  assign degenerate  = o_deg;

  `ASSERT_IMPL(a_skid_has_out, sk_vld, res_valid, "skid slot held without an output")
  `ASSERT_IMPL(a_deg_zero, res_valid && degenerate, axis_cos_x == '0 && perp_cos_y == '0 && third_cos_z == '0, "degenerate result with nonzero matrix")
  `ASSERT_IMPL(a_axis_nonzero, res_valid && !degenerate, axis_cos_x != '0 || axis_cos_y != '0 || axis_cos_z != '0, "bar axis row is all zero")
  `ASSERT_NEXT(a_drain, res_valid && !res_stall && !sk_vld && !vp[LAT], !res_valid, "output valid held after drain")

endmodule

>>> rtl/tdcm_norm.sv
// ----------------------------------------------------------------------------
// tdcm_norm
// Normalises one scaled 3-vector: squares, sum, pipelined integer square
// root, then one restoring quotient bit per stage, round and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdcm_norm import tdcm_pkg::*; #(
  parameter int OUT_BITS = 32
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [SCL_W-1:0]    v [3],
  output logic signed [OUT_BITS-1:0] u [3]
);

  localparam int FRAC = OUT_BITS - 2;
  localparam int QW   = FRAC + 1;
  localparam int SQW  = 2 * MAG_W;
  localparam int NW   = MAG_W + 1;

  logic [MAG_W-1:0] m1 [3];
  logic             n1 [3];
  logic [MAG_W-1:0] m2 [3];
  logic             n2 [3];
  logic [SQW-1:0]   sq2 [3];

  logic [63:0]      sq_x [0:SQRT_STEPS];
  logic [63:0]      sq_r [0:SQRT_STEPS];
  logic [MAG_W-1:0] sm [0:SQRT_STEPS][3];
  logic             sg [0:SQRT_STEPS][3];

  logic [NW-1:0]    dv_r [1:FRAC+1][3];
  logic [QW-1:0]    dv_q [1:FRAC+1][3];
  logic             dv_s [1:FRAC+1][3];
  logic [NW-1:0]    dv_n [1:FRAC+1];

  logic [OUT_BITS-1:0] rd_q [3];
  logic                rd_s [3];
  logic                rd_z;

  logic signed [SCL_W-1:0] vneg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) vneg[i] = -v[i];
  end

  always_ff @(posedge clk) begin
    logic [63:0]   bitv;
    logic [63:0]   trial;
    logic [NW:0]   rin;
    logic [NW:0]   nv;
    logic [NW:0]   rnew;
    logic          qb;
    if (en) begin
      // magnitudes, squares, sum of squares
      for (int i = 0; i < 3; i++) begin
        m1[i]  <= v[i][SCL_W-1] ? vneg[i][MAG_W-1:0] : v[i][MAG_W-1:0];
        n1[i]  <= v[i][SCL_W-1];
        m2[i]  <= m1[i];
        n2[i]  <= n1[i];
        sq2[i] <= SQW'(m1[i]) * SQW'(m1[i]);
        sm[0][i] <= m2[i];
        sg[0][i] <= n2[i];
      end
      sq_x[0] <= 64'(sq2[0]) + 64'(sq2[1]) + 64'(sq2[2]);
      sq_r[0] <= '0;

      // integer square root, one result bit per stage
      for (int k = 0; k < SQRT_STEPS; k++) begin
        bitv  = 64'd1 << (62 - 2 * k);
        trial = sq_r[k] + bitv;
        if (sq_x[k] >= trial) begin
          sq_x[k+1] <= sq_x[k] - trial;
          sq_r[k+1] <= (sq_r[k] >> 1) + bitv;
        end else begin
          sq_x[k+1] <= sq_x[k];
          sq_r[k+1] <= sq_r[k] >> 1;
        end
        for (int i = 0; i < 3; i++) begin
          sm[k+1][i] <= sm[k][i];
          sg[k+1][i] <= sg[k][i];
        end
      end

      // integer quotient bit
      nv = {1'b0, sq_r[SQRT_STEPS][NW-1:0]};
      dv_n[1] <= sq_r[SQRT_STEPS][NW-1:0];
      for (int i = 0; i < 3; i++) begin
        rin = {2'b00, sm[SQRT_STEPS][i]};
        qb  = (rin >= nv);
        rnew = qb ? rin - nv : rin;
        dv_r[1][i] <= rnew[NW-1:0];
        dv_q[1][i] <= {{(QW-1){1'b0}}, qb};
        dv_s[1][i] <= sg[SQRT_STEPS][i];
      end

      // fraction bits
      for (int j = 1; j <= FRAC; j++) begin
        nv = {1'b0, dv_n[j]};
        dv_n[j+1] <= dv_n[j];
        for (int i = 0; i < 3; i++) begin
          rin  = {dv_r[j][i], 1'b0};
          qb   = (rin >= nv);
          rnew = qb ? rin - nv : rin;
          dv_r[j+1][i] <= rnew[NW-1:0];
          dv_q[j+1][i] <= {dv_q[j][i][QW-2:0], qb};
          dv_s[j+1][i] <= dv_s[j][i];
        end
      end

      // round half up in magnitude
      nv = {1'b0, dv_n[FRAC+1]};
      rd_z <= (dv_n[FRAC+1] == '0);
      for (int i = 0; i < 3; i++) begin
        rin = {dv_r[FRAC+1][i], 1'b0};
        qb  = (rin >= nv);
        rd_q[i] <= {1'b0, dv_q[FRAC+1][i]} + OUT_BITS'(qb);
        rd_s[i] <= dv_s[FRAC+1][i];
      end

      // apply sign and saturate
      for (int i = 0; i < 3; i++) begin
        if (rd_z) u[i] <= '0;
        else if (rd_q[i][OUT_BITS-1])
          u[i] <= rd_s[i] ? signed'({1'b1, {(OUT_BITS-1){1'b0}}})
                          : signed'({1'b0, {(OUT_BITS-1){1'b1}}});
        else u[i] <= rd_s[i] ? -signed'(rd_q[i]) : signed'(rd_q[i]);
      end
    end
  end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Bar rotation matrix core testbench
// Drives node pairs through the core with random gaps and output stalls,
// predicts each 3x3 matrix in fixed point and compares every field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int CW       = 32;
  localparam int OW       = 32;
  localparam int FRAC     = OW - 2;
  localparam int LATENCY  = OW + 46;

  typedef struct {
    logic signed [OW-1:0] cosv [9];
    logic                 degen;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic signed [CW-1:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [CW-1:0] end_x = '0, end_y = '0, end_z = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  logic signed [OW-1:0] axis_cos_x, axis_cos_y, axis_cos_z;
  logic signed [OW-1:0] perp_cos_x, perp_cos_y, perp_cos_z;
  logic signed [OW-1:0] third_cos_x, third_cos_y, third_cos_z;
  logic degenerate;

  matrix_t pending_matrices[$];
  int      mismatches = 0;
  bit      hold_off = 1'b0;
  int      hold_cycles = 0;

  truss_direction_cosine_matrix_core #(.COORD_BITS(CW), .OUT_BITS(OW)) DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---- predictor ----------------------------------------------------------

  function automatic longint unsigned mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic void scale_vec(ref longint v[3]);
    longint unsigned m[3], mx;
    int rs, ls;
    mx = 0; rs = 0; ls = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag_of(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return;
    while (mx >= (64'd1 << 30)) begin mx >>= 1; rs++; end
    while (mx < (64'd1 << 29)) begin mx <<= 1; ls++; end
    for (int i = 0; i < 3; i++) begin
      m[i] = (m[i] >> rs) << ls;
      v[i] = v[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
    end
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r, b;
    r = 0; b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin x -= r + b; r = (r >> 1) + b; end
      else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned round_ratio(longint unsigned m, longint unsigned n);
    longint unsigned q, r;
    q = 0; r = m;
    if (r >= n) begin q = 1; r -= n; end
    for (int i = 0; i < FRAC; i++) begin
      r <<= 1; q <<= 1;
      if (r >= n) begin r -= n; q |= 1; end
    end
    r <<= 1;
    if (r >= n) q++;
    return q;
  endfunction

  function automatic void unit_vec(longint v[3], ref matrix_t mt, input int base);
    longint unsigned s, n, q, maxp;
    s = 0;
    maxp = (64'd1 << (OW - 1)) - 1;
    for (int i = 0; i < 3; i++) s += mag_of(v[i]) * mag_of(v[i]);
    n = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      if (n == 0) begin mt.cosv[base+i] = '0; continue; end
      q = round_ratio(mag_of(v[i]), n);
      if (q > maxp) q = (v[i] < 0) ? maxp + 1 : maxp;
      mt.cosv[base+i] = (v[i] < 0) ? OW'(-q) : OW'(q);
    end
  endfunction

  function automatic matrix_t rotation_of(longint sx, longint sy, longint sz,
                                          longint ex, longint ey, longint ez);
    matrix_t mt;
    longint d[3], p[3], c[3];
    d[0] = ex - sx; d[1] = ey - sy; d[2] = ez - sz;
    mt.degen = 1'b0;
    if (d[0] == 0 && d[1] == 0 && d[2] == 0) begin
      foreach (mt.cosv[i]) mt.cosv[i] = '0;
      mt.degen = 1'b1;
      return mt;
    end
    scale_vec(d);
    if (d[0] != 0) begin
      p[0] = d[0] > 0 ? -(d[1] + d[2]) : d[1] + d[2];
      p[1] = mag_of(d[0]); p[2] = p[1];
    end else if (d[1] != 0) begin
      p[0] = mag_of(d[1]); p[1] = d[1] > 0 ? -d[2] : d[2]; p[2] = p[0];
    end else begin
      p[0] = mag_of(d[2]); p[1] = p[0]; p[2] = d[2] > 0 ? -d[1] : d[1];
    end
    c[0] = d[1] * p[2] - d[2] * p[1];
    c[1] = d[2] * p[0] - d[0] * p[2];
    c[2] = d[0] * p[1] - d[1] * p[0];
    scale_vec(p);
    scale_vec(c);
    unit_vec(d, mt, 0);
    unit_vec(p, mt, 3);
    unit_vec(c, mt, 6);
    return mt;
  endfunction

  // ---- sender -------------------------------------------------------------

  task automatic send_bar(logic signed [CW-1:0] sx, sy, sz, ex, ey, ez);
    @(negedge clk);
    req_valid <= 1'b1;
    start_x <= sx; start_y <= sy; start_z <= sz;
    end_x <= ex; end_y <= ey; end_z <= ez;
    pending_matrices.push_back(rotation_of(sx, sy, sz, ex, ey, ez));
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    req_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_wait();
    int guard;
    guard = 0;
    while (pending_matrices.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  function automatic logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
      1: return CW'($signed($urandom_range(0, 64)) - 32);
      2: return CW'($signed($urandom_range(0, 20000)) - 10000) << $urandom_range(0, 16);
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_random();
    logic [CW-1:0] s[3], e[3];
    int shape;
    for (int i = 0; i < 3; i++) begin s[i] = rnd_coord(); e[i] = rnd_coord(); end
    shape = $urandom_range(0, 9);
    // pull some axes together to hit the branch choice and coincident nodes
    if (shape == 0) e = s;
    else if (shape <= 3) e[0] = s[0];
    else if (shape == 4) begin e[0] = s[0]; e[1] = s[1]; end
    else if (shape == 5) e[$urandom_range(0, 2)] = s[$urandom_range(0, 2)] + 1;
    send_bar(s[0], s[1], s[2], e[0], e[1], e[2]);
  endtask

  // ---- tests --------------------------------------------------------------

  task automatic test_directed();
    logic signed [CW-1:0] mx, mn;
    mx = 32'sh7fffffff; mn = 32'sh80000000;
    send_bar(0, 0, 0, 0, 0, 0);
    send_bar(mx, mn, 5, mx, mn, 5);
    send_bar(0, 0, 0, 32'h10000, 0, 0);
    send_bar(0, 0, 0, -32'sh10000, 0, 0);
    send_bar(0, 0, 0, 0, 32'h10000, 0);
    send_bar(0, 0, 0, 0, -32'sh10000, 0);
    send_bar(0, 0, 0, 0, 0, 32'h10000);
    send_bar(0, 0, 0, 0, 0, -32'sh10000);
    send_bar(mn, mn, mn, mx, mx, mx);
    send_bar(mx, mx, mx, mn, mn, mn);
    send_bar(mn, 0, 0, mx, 0, 0);
    send_bar(0, mx, 0, 0, mn, 0);
    send_bar(0, 0, mn, 0, 0, mx);
    // tiny component vanishes under scaling and counts as zero
    send_bar(0, 0, 0, 1, mx, 0);
    send_bar(0, mn, 0, -1, mx, 1);
    send_bar(0, 0, 0, 1, 1, 1);
    send_bar(0, 0, 0, -1, 1, -1);
    send_bar(1, 2, 3, 4, 6, 8);
    send_bar(-1, -1, -1, 0, 0, 0);
    send_bar(mx, 0, mn, mn, 1, mx);
    idle_sender(1);
    drain_wait();
  endtask

  task automatic test_random_bursts(int items);
    int done;
    done = 0;
    while (done < items) begin
      int burst;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && done < items; i++) begin
        send_random();
        done++;
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(0, 12));
    end
    idle_sender(1);
  endtask

  task automatic test_backpressure();
    hold_cycles = 400;
    hold_off = 1'b1;
    for (int i = 0; i < 150; i++) send_random();
    idle_sender(1);
    drain_wait();
  endtask

  // ---- receiver -----------------------------------------------------------

  always @(negedge clk) begin
    if (hold_off) begin
      res_stall <= 1'b1;
      if (hold_cycles == 0) hold_off <= 1'b0;
      else hold_cycles <= hold_cycles - 1;
    end else begin
      case (($time / 2000) % 3)
        0: res_stall <= 1'b0;
        1: res_stall <= ($urandom_range(0, 3) == 0);
        default: res_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      matrix_t want;
      logic signed [OW-1:0] got [9];
      bit bad;
      got = '{axis_cos_x, axis_cos_y, axis_cos_z, perp_cos_x, perp_cos_y, perp_cos_z,
              third_cos_x, third_cos_y, third_cos_z};
      if (pending_matrices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
      end else begin
        want = pending_matrices.pop_front();
        bad = (degenerate !== want.degen);
        for (int i = 0; i < 9; i++) if (got[i] !== want.cosv[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t: degenerate exp %0b got %0b", $realtime,
                     want.degen, degenerate);
            for (int i = 0; i < 9; i++)
              $display("  cos[%0d] exp %h got %h", i, want.cosv[i], got[i]);
          end
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random_bursts(1030);
    drain_wait();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && pending_matrices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
